/* design/ntc_pkg.sv */
package ntc_pkg;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_BETA    = 2'd0;
    localparam logic [1:0] REG_SERIES  = 2'd1;
    localparam logic [1:0] REG_NOMINAL = 2'd2;

    // Field widths
    localparam int BETA_W = 14;
    localparam int OHM_W  = 20;
    localparam int CODE_W = 12;
    localparam int TEMP_W = 17;

    localparam logic [BETA_W-1:0] BETA_RESET    = 14'd3950;
    localparam logic [OHM_W-1:0]  SERIES_RESET  = 20'd10000;
    localparam logic [OHM_W-1:0]  NOMINAL_RESET = 20'd10000;

    // Rail status codes
    localparam logic [1:0] RAIL_NONE = 2'd0;
    localparam logic [1:0] RAIL_ZERO = 2'd1;
    localparam logic [1:0] RAIL_FULL = 2'd2;

    // log2 formats: Q30 mantissa, result {5-bit integer, 28-bit fraction}
    localparam int FRAC_LOG = 28;
    localparam int MANT_W   = 31;
    localparam int K_W      = 5;
    localparam int LOG_W    = K_W + FRAC_LOG;

    localparam logic [FRAC_LOG-1:0] LN2_Q28 = 28'd186065280;
    // 1/298.15 K in Q40, rounded
    localparam logic [63:0] INV_T0_Q40 =
        ((64'd1 << 40) * 64'd20 + 64'd5963 / 64'd2) / 64'd5963;
    localparam logic [63:0] CENTI_K_NUM = 64'd100 << 40;

    localparam logic [16:0]              TCK_MAX        = 17'd87315;
    localparam logic signed [17:0]       KELVIN_OFFSET  = 18'sd27315;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN       = -17'sd10000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX       = 17'sd60000;
    localparam logic signed [TEMP_W-1:0] TEMP_FULL      = 17'sd9900;
    localparam logic signed [TEMP_W-1:0] TEMP_ZERO      = 17'sd0;

    typedef struct packed {
        logic [CODE_W-1:0] adc_code;
        logic [1:0]        sensor_index;
    } sample_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature_centi;
        logic [1:0]               sensor_tag;
        logic [1:0]               rail_status;
    } result_t;

    typedef struct packed {
        logic [1:0] tag;
        logic [1:0] status;
    } meta_t;

endpackage

/* design/ntc_thermistor_to_celsius_core.sv */
// NTC thermistor to Celsius, beta equation. Fully pipelined: one item is taken every cycle
// while the output is not stalled; a stall at the output freezes the whole pipeline. The
// pipeline depth is set by the 28 squaring stages of the four parallel log2 lanes (series,
// code, full scale minus code, nominal) and by two bit-per-stage restoring dividers: 46
// stages for ln/beta and 17 for the final reciprocal to centi-kelvin. Codes of zero and full
// scale give 0 C and 99 C with the rail status set; other results saturate to -100..600 C.
// Registers at byte 0 (beta), 4 (series ohms), 8 (nominal ohms); a register written as zero
// acts as one. Write registers only while no item is in flight.
module ntc_thermistor_to_celsius_core #(
    parameter int ADC_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_ready,
    input  ntc_pkg::sample_t          sample,
    output logic                      result_valid,
    input  logic                      result_ready,
    output ntc_pkg::result_t          result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [ntc_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import ntc_pkg::*;

    localparam int XW      = OHM_W;
    localparam int SQ_N    = FRAC_LOG;
    localparam int MAG_W   = LOG_W + 1;
    localparam int DIV1_W  = MAG_W + 12;
    localparam int INV_W   = DIV1_W + 2;
    localparam int D_W     = INV_W - 1;
    localparam int N_W     = D_W + 1;
    localparam int DIV2_W  = 17;
    // stage count: input, normalize + squarings, sum, ln, div1, inv, div2, output
    localparam int NST     = 1 + (SQ_N + 1) + 1 + 1 + DIV1_W + 1 + DIV2_W + 1;
    localparam logic [XW-1:0] FULL_SCALE = XW'((32'd1 << ADC_BITS) - 32'd1);

    // ---------------- configuration ----------------
    logic [BETA_W-1:0] beta_reg;
    logic [OHM_W-1:0]  series_reg;
    logic [OHM_W-1:0]  nominal_reg;
    logic [1:0]        reg_idx;
    logic              cfg_write;
    logic [BETA_W-1:0] beta_eff;
    logic [OHM_W-1:0]  series_eff;
    logic [OHM_W-1:0]  nominal_eff;

    assign reg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel & penable & pwrite;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beta_reg    <= BETA_RESET;
            series_reg  <= SERIES_RESET;
            nominal_reg <= NOMINAL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_BETA:    beta_reg    <= pwdata[BETA_W-1:0];
                REG_SERIES:  series_reg  <= pwdata[OHM_W-1:0];
                REG_NOMINAL: nominal_reg <= pwdata[OHM_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_BETA:    prdata = 32'(beta_reg);
            REG_SERIES:  prdata = 32'(series_reg);
            REG_NOMINAL: prdata = 32'(nominal_reg);
            default:     prdata = '0;
        endcase
    end

    assign beta_eff    = (beta_reg == '0)    ? BETA_W'(1) : beta_reg;
    assign series_eff  = (series_reg == '0)  ? OHM_W'(1)  : series_reg;
    assign nominal_eff = (nominal_reg == '0) ? OHM_W'(1)  : nominal_reg;

    // ---------------- pipeline control ----------------
    logic           en;
    logic [NST-1:0] vld_reg;
    meta_t          meta_reg [NST];
    meta_t          meta_in;

    assign en           = ~vld_reg[NST-1] | result_ready;
    assign sample_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST-2:0], sample_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            meta_reg[0] <= meta_in;
            for (int s = 1; s < NST; s++)
                meta_reg[s] <= meta_reg[s-1];
        end
    end

    // ---------------- input stage ----------------
    logic [15:0]   code_wide;
    logic [XW-1:0] code_x;
    logic [XW-1:0] x_reg  [4];
    logic [XW-1:0] x_next [4];

    assign code_wide = 16'(sample.adc_code);
    assign code_x    = XW'(code_wide[ADC_BITS-1:0]);

    always_comb
    begin
        meta_in.tag = sample.sensor_index;
        if (code_x == '0)
            meta_in.status = RAIL_ZERO;
        else if (code_x >= FULL_SCALE)
            meta_in.status = RAIL_FULL;
        else
            meta_in.status = RAIL_NONE;
        x_next[0] = series_eff;
        x_next[1] = code_x;
        x_next[2] = FULL_SCALE - code_x;    // garbage on the rails, result is overridden
        x_next[3] = nominal_eff;
    end

    // ---------------- log2 lanes: normalize, then square-and-halve ----------------
    logic [MANT_W-1:0] sqm_reg  [SQ_N+1][4];
    logic [MANT_W-1:0] sqm_next [SQ_N+1][4];
    logic [LOG_W-1:0]  sqa_reg  [SQ_N+1][4];
    logic [LOG_W-1:0]  sqa_next [SQ_N+1][4];

    always_comb
    begin
        logic [K_W-1:0]           k;
        logic [K_W-1:0]           sh;
        logic [XW+MANT_W-1:0]     wide;
        logic [2*MANT_W-1:0]      prod;
        logic [MANT_W:0]          top;
        for (int l = 0; l < 4; l++)
        begin
            k = '0;
            for (int b = 0; b < XW; b++)
                if (x_reg[l][b])
                    k = K_W'(b);
            sh   = K_W'(MANT_W - 1) - k;
            wide = (XW+MANT_W)'(x_reg[l]) << sh;
            sqm_next[0][l] = wide[MANT_W-1:0];
            // integer part rides in the low bits and is shifted up by the fraction bits
            sqa_next[0][l] = LOG_W'(k);
            for (int j = 1; j <= SQ_N; j++)
            begin
                prod = sqm_reg[j-1][l] * sqm_reg[j-1][l];
                top  = prod[2*MANT_W-1:MANT_W-1];
                sqm_next[j][l] = top[MANT_W] ? top[MANT_W:1] : top[MANT_W-1:0];
                sqa_next[j][l] = {sqa_reg[j-1][l][LOG_W-2:0], top[MANT_W]};
            end
        end
    end

    // ---------------- sum, ln, reciprocal-temperature, numerator ----------------
    logic [MAG_W:0]     l2;
    logic [MAG_W:0]     l2_abs;
    logic [MAG_W-1:0]   mag_reg;
    logic               neg_reg;
    logic [MAG_W+FRAC_LOG-1:0] ln_prod;
    logic [MAG_W-1:0]   ln_reg;
    logic               ln_neg_reg;

    logic [BETA_W-1:0]  d1r_reg  [DIV1_W];
    logic [BETA_W-1:0]  d1r_next [DIV1_W];
    logic [DIV1_W-1:0]  d1w_reg  [DIV1_W];
    logic [DIV1_W-1:0]  d1w_next [DIV1_W];
    logic               d1n_reg  [DIV1_W];

    logic [INV_W-1:0]   inv;
    logic [D_W-1:0]     d_reg;
    logic               nonpos_reg;
    logic [N_W-1:0]     num;
    logic               big;

    logic [D_W-1:0]     d2r_reg  [DIV2_W];
    logic [D_W-1:0]     d2r_next [DIV2_W];
    logic [DIV2_W-1:0]  d2w_reg  [DIV2_W];
    logic [DIV2_W-1:0]  d2w_next [DIV2_W];
    logic [D_W-1:0]     d2d_reg  [DIV2_W];
    logic               d2s_reg  [DIV2_W];

    logic [DIV2_W-1:0]        tck;
    logic signed [17:0]       diff;
    logic signed [TEMP_W-1:0] temp_next;
    logic signed [TEMP_W-1:0] temp_reg;

    always_comb
    begin
        l2 = (MAG_W+1)'(sqa_reg[SQ_N][0]) + (MAG_W+1)'(sqa_reg[SQ_N][1])
           - (MAG_W+1)'(sqa_reg[SQ_N][2]) - (MAG_W+1)'(sqa_reg[SQ_N][3]);
        l2_abs  = l2[MAG_W] ? (~l2 + 1'b1) : l2;
        ln_prod = mag_reg * LN2_Q28;
        inv = d1n_reg[DIV1_W-1] ? INV_W'(INV_T0_Q40) - INV_W'(d1w_reg[DIV1_W-1])
                                : INV_W'(INV_T0_Q40) + INV_W'(d1w_reg[DIV1_W-1]);
        num = N_W'(CENTI_K_NUM) + N_W'(d_reg >> 1);
        big = (N_W+DIV2_W)'(num) >= ((N_W+DIV2_W)'(d_reg) << DIV2_W);
    end

    // ln/beta: restoring divider, one quotient bit per stage
    always_comb
    begin
        logic [BETA_W-1:0] r;
        logic [DIV1_W-1:0] w;
        logic [BETA_W:0]   t;
        logic              ge;
        for (int s = 0; s < DIV1_W; s++)
        begin
            if (s == 0)
            begin
                r = '0;
                w = {ln_reg, 12'b0};
            end
            else
            begin
                r = d1r_reg[s-1];
                w = d1w_reg[s-1];
            end
            t  = {r, w[DIV1_W-1]};
            ge = t >= {1'b0, beta_eff};
            d1r_next[s] = ge ? BETA_W'(t - {1'b0, beta_eff}) : t[BETA_W-1:0];
            d1w_next[s] = {w[DIV1_W-2:0], ge};
        end
    end

    // centi-kelvin = num / d; only 17 quotient bits are kept, larger ones saturate
    always_comb
    begin
        logic [D_W-1:0]    r;
        logic [DIV2_W-1:0] w;
        logic [D_W-1:0]    dv;
        logic [D_W:0]      t;
        logic              ge;
        for (int s = 0; s < DIV2_W; s++)
        begin
            if (s == 0)
            begin
                r = D_W'(num >> DIV2_W);
                w = num[DIV2_W-1:0];
            end
            else
            begin
                r = d2r_reg[s-1];
                w = d2w_reg[s-1];
            end
            dv = (s == 0) ? d_reg : d2d_reg[s-1];
            t  = {r, w[DIV2_W-1]};
            ge = t >= {1'b0, dv};
            d2r_next[s] = ge ? D_W'(t - {1'b0, dv}) : t[D_W-1:0];
            d2w_next[s] = {w[DIV2_W-2:0], ge};
        end
    end

    always_comb
    begin
        tck  = d2w_reg[DIV2_W-1];
        diff = $signed({1'b0, tck}) - KELVIN_OFFSET;
        if (meta_reg[NST-2].status == RAIL_ZERO)
            temp_next = TEMP_ZERO;
        else if (meta_reg[NST-2].status == RAIL_FULL)
            temp_next = TEMP_FULL;
        else if (d2s_reg[DIV2_W-1] || tck > TCK_MAX)
            temp_next = TEMP_MAX;
        else if (diff < 18'(TEMP_MIN))
            temp_next = TEMP_MIN;
        else
            temp_next = TEMP_W'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= x_next;
            sqm_reg    <= sqm_next;
            sqa_reg    <= sqa_next;
            mag_reg    <= l2_abs[MAG_W-1:0];
            neg_reg    <= l2[MAG_W];
            ln_reg     <= ln_prod[MAG_W+FRAC_LOG-1:FRAC_LOG];
            ln_neg_reg <= neg_reg;
            d1r_reg    <= d1r_next;
            d1w_reg    <= d1w_next;
            d1n_reg[0] <= ln_neg_reg;
            for (int s = 1; s < DIV1_W; s++)
                d1n_reg[s] <= d1n_reg[s-1];
            d_reg      <= inv[D_W-1:0];
            nonpos_reg <= inv[INV_W-1] | (inv == '0);
            d2r_reg    <= d2r_next;
            d2w_reg    <= d2w_next;
            d2d_reg[0] <= d_reg;
            d2s_reg[0] <= nonpos_reg | big;
            for (int s = 1; s < DIV2_W; s++)
            begin
                d2d_reg[s] <= d2d_reg[s-1];
                d2s_reg[s] <= d2s_reg[s-1];
            end
            temp_reg   <= temp_next;
        end
    end

    assign result_valid             = vld_reg[NST-1];
    assign result.temperature_centi = temp_reg;
    assign result.sensor_tag        = meta_reg[NST-1].tag;
    assign result.rail_status       = meta_reg[NST-1].status;

endmodule

/* design/ntc_checker.sv */
module ntc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       sample_valid,
    input logic                       sample_ready,
    input ntc_pkg::sample_t           sample,
    input logic                       result_valid,
    input logic                       result_ready,
    input ntc_pkg::result_t           result,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [ntc_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]                pwdata,
    input logic [31:0]                prdata,
    input logic                       pready
);
    import ntc_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed under stall");

    // pipeline only backs up when a result is waiting
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("input stalled with empty output");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.rail_status == RAIL_ZERO |-> result.temperature_centi == TEMP_ZERO)
        else $error("zero code not mapped to 0 C");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.rail_status == RAIL_FULL |-> result.temperature_centi == TEMP_FULL)
        else $error("full scale not mapped to 99 C");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.temperature_centi >= TEMP_MIN
                      && result.temperature_centi <= TEMP_MAX
                      && result.rail_status <= RAIL_FULL)
        else $error("result out of range");

endmodule

bind ntc_thermistor_to_celsius_core ntc_checker u_ntc_checker (.*);

/* verif/ntc_thermistor_to_celsius_core_test.sv */
module ntc_thermistor_to_celsius_core_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ntc_pkg::*;

    localparam int FS = (1 << CODE_W) - 1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic sample_valid = 1'b0;
    logic sample_ready;
    sample_t sample = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    ntc_thermistor_to_celsius_core dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
        .result_valid(result_valid), .result_ready(result_ready), .result(result),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [63:0] beta_q = BETA_RESET;
    logic [63:0] series_q = SERIES_RESET;
    logic [63:0] nominal_q = NOMINAL_RESET;

    result_t temp_queue[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int n_rails = 0;
    bit hold_off = 1'b0;
    bit stall_en = 1'b1;

    function automatic longint log2_fix(longint unsigned x);
        int k;
        longint unsigned m;
        longint r;
        if (x == 0) x = 1;
        k = 0;
        while (k < 31 && (x >> (k + 1)) != 0) k++;
        m = x << (30 - k);
        r = longint'(k) << FRAC_LOG;
        for (int i = 1; i <= FRAC_LOG; i++)
        begin
            m = (m * m) >> 30;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                r += longint'(1) << (FRAC_LOG - i);
            end
        end
        return r;
    endfunction

    function automatic result_t celsius_of(sample_t s);
        result_t r;
        longint unsigned code, bt, sr, nm, mag, lnm, q, d, tck;
        longint l2, inv, t;
        bit neg;
        code = s.adc_code;
        r.sensor_tag = s.sensor_index;
        if (code == 0)
        begin
            r.temperature_centi = TEMP_ZERO;
            r.rail_status = RAIL_ZERO;
            return r;
        end
        if (code >= FS)
        begin
            r.temperature_centi = TEMP_FULL;
            r.rail_status = RAIL_FULL;
            return r;
        end
        bt = beta_q ? beta_q : 1;
        sr = series_q ? series_q : 1;
        nm = nominal_q ? nominal_q : 1;
        l2 = log2_fix(sr) + log2_fix(code) - log2_fix(FS - code) - log2_fix(nm);
        neg = l2 < 0;
        mag = neg ? -l2 : l2;
        lnm = (mag * 64'd186065280) >> FRAC_LOG;
        q = (lnm << 12) / bt;
        inv = longint'(INV_T0_Q40) + (neg ? -longint'(q) : longint'(q));
        r.rail_status = RAIL_NONE;
        if (inv <= 0) t = 60000;
        else
        begin
            d = inv;
            tck = (CENTI_K_NUM + d / 2) / d;
            if (tck > 87315) t = 60000;
            else
            begin
                t = longint'(tck) - 27315;
                if (t < -10000) t = -10000;
            end
        end
        r.temperature_centi = t[TEMP_W-1:0];
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (temp_queue.size() == 0)
            begin
                $error("unexpected result %p", result);
                errors++;
            end
            else
            begin
                e = temp_queue.pop_front();
                if (result.temperature_centi !== e.temperature_centi)
                begin
                    $error("temperature_centi exp %0d got %0d",
                           e.temperature_centi, result.temperature_centi);
                    errors++;
                end
                if (result.sensor_tag !== e.sensor_tag)
                begin
                    $error("sensor_tag exp %0d got %0d", e.sensor_tag, result.sensor_tag);
                    errors++;
                end
                if (result.rail_status !== e.rail_status)
                begin
                    $error("rail_status exp %0d got %0d", e.rail_status, result.rail_status);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin
        if (hold_off) result_ready <= 1'b0;
        else if (!stall_en) result_ready <= 1'b1;
        else result_ready <= ($urandom_range(0, 3) != 0);
    end

    task automatic send_sample(logic [CODE_W-1:0] code, logic [1:0] idx);
        sample_t s;
        s.adc_code = code;
        s.sensor_index = idx;
        sample <= s;
        sample_valid <= 1'b1;
        temp_queue.push_back(celsius_of(s));
        if (code == 0 || code == FS) n_rails++;
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
        n_sent++;
    endtask

    task automatic idle_gap();
        int g;
        g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
        if (g > 0)
        begin
            sample_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (temp_queue.size() != 0) @(posedge clk);
        repeat (120) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [31:0] v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_W'(idx) << 2; pwdata <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_BETA: beta_q = v[BETA_W-1:0];
            REG_SERIES: series_q = v[OHM_W-1:0];
            REG_NOMINAL: nominal_q = v[OHM_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_regs(logic [31:0] b, logic [31:0] s, logic [31:0] n);
        reg_write(REG_BETA, b);
        reg_write(REG_SERIES, s);
        reg_write(REG_NOMINAL, n);
    endtask

    task automatic test_directed();
        logic [CODE_W-1:0] codes[12] = '{0, 1, 2, FS - 1, FS, 2048, 2047, 1000,
                                         3000, 12'h555, 12'haaa, 100};
        foreach (codes[i]) send_sample(codes[i], i[1:0]);
        drain();
    endtask

    task automatic test_random(int n);
        int burst;
        logic [CODE_W-1:0] c;
        while (n > 0)
        begin
            burst = $urandom_range(1, 20);
            repeat (burst)
            begin
                case ($urandom_range(0, 9))
                    0: c = '0;
                    1: c = CODE_W'(FS);
                    2: c = CODE_W'($urandom_range(1, 40));
                    3: c = CODE_W'($urandom_range(FS - 40, FS - 1));
                    default: c = CODE_W'($urandom);
                endcase
                send_sample(c, 2'($urandom));
                n--;
            end
            idle_gap();
        end
        drain();
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(posedge clk);
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 200; i++) send_sample(CODE_W'($urandom), 2'($urandom));
            end
        join
        drain();
    endtask

    task automatic test_settings();
        set_regs(1000, 100, 1000000);
        test_random(60);
        set_regs(10000, 1000000, 100);
        test_random(60);
        set_regs(0, 0, 0);
        test_directed();
        set_regs(14'h3fff, 20'hfffff, 20'hfffff);
        test_random(40);
        set_regs($urandom_range(1000, 10000), $urandom_range(100, 1000000),
                 $urandom_range(100, 1000000));
        test_random(60);
        set_regs(3950, 10000, 10000);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        stall_en = 1'b0;
        test_random(60);
        stall_en = 1'b1;
        test_random(200);
        test_backpressure();
        test_settings();
        test_random(60);
        $display("items sent %0d, results checked %0d, rail codes %0d",
                 n_sent, n_checked, n_rails);
        $display("covered extreme codes, all registers at extremes, stalls and backpressure");
        if (errors == 0 && temp_queue.size() == 0)
            $display("[ntc_thermistor_to_celsius_core] OK");
        else
            $display("[ntc_thermistor_to_celsius_core] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[ntc_thermistor_to_celsius_core] ERROR");
        $finish;
    end
endmodule
